// ===== hdl/indexed_array_list_core_assert.svh =====
// Assertion macros for the indexed array list core.
`ifndef INDEXED_ARRAY_LIST_CORE_ASSERT_SVH
`define INDEXED_ARRAY_LIST_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define IAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed_array_list_core: check failed");

// Next-cycle implication, disabled while reset is asserted
`define IAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed_array_list_core: check failed");

`else

`define IAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define IAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/ial_pkg.sv =====
package ial_pkg;

    // List geometry
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Fixed field widths of a request and a result
    localparam int KIND_W   = 3;
    localparam int INDEX_W  = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Common width for comparing a request index with the fill count
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // Operation kinds
    localparam logic [KIND_W-1:0] KIND_GET          = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET          = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ADD_FIRST    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ADD_LAST     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_REMOVE_FIRST = 3'd6;
    localparam logic [KIND_W-1:0] KIND_REMOVE_LAST  = 3'd7;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Cell row commands
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_WRITE  = 2'd1;
    localparam logic [1:0] CELL_INSERT = 2'd2;
    localparam logic [1:0] CELL_DELETE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_data;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
    } rsp_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic [1:0]            mode;
        logic [IDX_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] data;
    } cell_cmd_t;

    // Decode outcome handed from the controller to the result stage
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                read_hit;
        logic [CNT_W-1:0]    fill;
        logic [CNT_W-1:0]    fill_next;
    } ctrl_stat_t;

    // Stored form: low DATA_WIDTH bits of the sign-extended value
    function automatic logic [DATA_WIDTH-1:0] to_cell_word(input logic signed [VALUE_W-1:0] v);
        logic signed [63:0] wide;
        wide = 64'(v);
        return wide[DATA_WIDTH-1:0];
    endfunction

    // Read form: sign-extend the stored word, keep the low 32 bits
    function automatic logic signed [VALUE_W-1:0] from_cell_word(input logic [DATA_WIDTH-1:0] w);
        logic signed [63:0] wide;
        wide = 64'($signed(w));
        return wide[VALUE_W-1:0];
    endfunction

endpackage

// ===== hdl/indexed_array_list_core.sv =====
// Indexed array list core: an ordered list of up to CAPACITY signed words held in a row of
// cells, one word per cell. A request is taken at any rising edge with start high; busy stays
// low, so a new request may follow in every cycle. Each request gives exactly one result,
// shown for a single cycle with done high, in the cycle after the request was taken. The result
// cannot be held off, so capture it in the cycle that done is high. Inserts and deletes move
// words from the position on by one cell in the same edge, which sets the rate at one
// request per cycle. A failed request (index out of range, list empty, list full) leaves the
// list and its count untouched. read_data is zero for anything but a successful get.
`include "indexed_array_list_core_assert.svh"

module indexed_array_list_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ial_pkg::req_t req,
    output logic          done,
    output ial_pkg::rsp_t rsp
);
    import ial_pkg::*;

    logic                  accept;
    cell_cmd_t             cmd;
    ctrl_stat_t            stat;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] read_word;

    logic                  done_reg;
    logic                  done_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    // every request completes in the edge that takes it
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // decode the request and hold the fill count
    ial_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .cmd    (cmd),
        .stat   (stat)
    );

    // row of cells; each sees its neighbours, the ends see themselves
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (g == 0)
        begin : g_first
            assign left_data = cell_data[g];
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[g];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[g+1];
        end

        ial_cell u_cell (
            .clk        (clk),
            .slot       (IDX_W'(g)),
            .cmd        (cmd),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[g])
        );
    end

    // pick the addressed word before the row moves; only used on a get in range
    assign read_word = cell_data[IDX_W'(req.index)];

    always_comb
    begin
        rsp_next.read_data = stat.read_hit ? from_cell_word(read_word) : '0;
        rsp_next.status    = stat.status;
        rsp_next.count     = COUNT_W'(stat.fill_next);
        rsp_next.is_empty  = stat.fill_next == '0;
        done_next          = accept;
    end

    // strobe the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    // hold the result payload for the strobe cycle
    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `IAL_ASSERT_NXT(a_done_after_req, clk, rst_n, accept, done_reg)
    `IAL_ASSERT_NXT(a_no_stray_done, clk, rst_n, !accept, !done_reg)
    `IAL_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, stat.fill <= CNT_W'(CAPACITY))
    `IAL_ASSERT_IMP(a_fail_keeps_count, clk, rst_n, done_reg && rsp_reg.status != ST_OK, stat.fill == $past(stat.fill))

endmodule

// ===== hdl/ial_cell.sv =====
module ial_cell (
    input  logic                           clk,
    input  logic [ial_pkg::IDX_W-1:0]      slot,
    input  ial_pkg::cell_cmd_t             cmd,
    input  logic [ial_pkg::DATA_WIDTH-1:0] left_data,
    input  logic [ial_pkg::DATA_WIDTH-1:0] right_data,
    output logic [ial_pkg::DATA_WIDTH-1:0] data
);
    import ial_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.mode)
            CELL_WRITE:
            begin
                if (slot == cmd.pos)
                    data_next = cmd.data;
            end
            CELL_INSERT:
            begin
                // take from below above the gap, drop the new word into it
                if (slot > cmd.pos)
                    data_next = left_data;
                else if (slot == cmd.pos)
                    data_next = cmd.data;
            end
            CELL_DELETE:
            begin
                // close the gap from above
                if (slot >= cmd.pos)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== hdl/ial_ctrl.sv =====
module ial_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  ial_pkg::req_t       req,
    output ial_pkg::cell_cmd_t  cmd,
    output ial_pkg::ctrl_stat_t stat
);
    import ial_pkg::*;

    logic [CNT_W-1:0]    fill_count_reg;
    logic [CNT_W-1:0]    fill_count_next;
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    fill_ext;
    logic                in_range;
    logic                ins_range;
    logic                full;
    logic                empty;
    logic [STATUS_W-1:0] status;
    logic                read_hit;
    logic [1:0]          mode;
    logic [IDX_W-1:0]    pos;
    logic [CNT_W-1:0]    fill_after;

    assign idx_ext   = CMP_W'(req.index);
    assign fill_ext  = CMP_W'(fill_count_reg);
    assign in_range  = idx_ext < fill_ext;
    assign ins_range = idx_ext <= fill_ext;
    assign full      = fill_count_reg >= CNT_W'(CAPACITY);
    assign empty     = fill_count_reg == '0;

    always_comb
    begin
        status     = ST_OK;
        read_hit   = 1'b0;
        mode       = CELL_HOLD;
        pos        = IDX_W'(req.index);
        fill_after = fill_count_reg;
        case (req.kind)
            KIND_GET:
            begin
                if (!in_range)
                    status = ST_RANGE;
                else
                    read_hit = 1'b1;
            end
            KIND_SET:
            begin
                if (!in_range)
                    status = ST_RANGE;
                else
                    mode = CELL_WRITE;
            end
            KIND_INSERT:
            begin
                if (!ins_range)
                    status = ST_RANGE;
                else if (full)
                    status = ST_FULL;
                else
                begin
                    mode       = CELL_INSERT;
                    fill_after = fill_count_reg + CNT_W'(1);
                end
            end
            KIND_DELETE:
            begin
                if (!in_range)
                    status = ST_RANGE;
                else
                begin
                    mode       = CELL_DELETE;
                    fill_after = fill_count_reg - CNT_W'(1);
                end
            end
            KIND_ADD_FIRST:
            begin
                pos = '0;
                if (full)
                    status = ST_FULL;
                else
                begin
                    mode       = CELL_INSERT;
                    fill_after = fill_count_reg + CNT_W'(1);
                end
            end
            KIND_ADD_LAST:
            begin
                // a list that is not full has its tail slot inside the row
                pos = IDX_W'(fill_count_reg);
                if (full)
                    status = ST_FULL;
                else
                begin
                    mode       = CELL_INSERT;
                    fill_after = fill_count_reg + CNT_W'(1);
                end
            end
            KIND_REMOVE_FIRST:
            begin
                pos = '0;
                if (empty)
                    status = ST_EMPTY;
                else
                begin
                    mode       = CELL_DELETE;
                    fill_after = fill_count_reg - CNT_W'(1);
                end
            end
            KIND_REMOVE_LAST:
            begin
                // the tail word is simply forgotten
                if (empty)
                    status = ST_EMPTY;
                else
                    fill_after = fill_count_reg - CNT_W'(1);
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign fill_count_next = accept ? fill_after : fill_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_count_reg <= '0;
        else
            fill_count_reg <= fill_count_next;
    end

    assign cmd.mode = accept ? mode : CELL_HOLD;
    assign cmd.pos  = pos;
    assign cmd.data = to_cell_word(req.value);

    assign stat.status    = status;
    assign stat.read_hit  = read_hit;
    assign stat.fill      = fill_count_reg;
    assign stat.fill_next = fill_after;

endmodule
